### hdl/gmpdp_pkg.sv
// Shared definitions for the grid maximum-path block: field widths, register
// codes, the controller state type and the saturating score adder.
// No dependencies.
package gmpdp_pkg;

  localparam int CFG_W        = 5;
  localparam int WEIGHT_W     = 8;
  localparam int SCORE_W      = 14;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;
  localparam int DEF_MAX_ROWS = 16;
  localparam int DEF_MAX_COLS = 16;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [CFG_W-1:0]   DIM_RESET = CFG_W'(16);

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_TB_RD,
    ST_TB_MV,
    ST_EMIT,
    ST_SCORE
  } gmpdp_state_e;

  function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                 input logic [WEIGHT_W-1:0] b);
    logic [SCORE_W:0] sum;
    sum = {1'b0, a} + {{(SCORE_W+1-WEIGHT_W){1'b0}}, b};
    return sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
  endfunction

endpackage

### hdl/grid_max_path_dp.sv
// Grid maximum-path engine: per-node score update against a score-row memory,
// direction bits in a second memory, traceback and path output.
// Depends on gmpdp_pkg.
//
// Usage: grid nodes enter on the input channel in raster order, one word per
// node carrying the north and west edge weights. A word is taken when
// in_valid_i is high and in_stall_o is low. For each node the block first reads
// its column's score from the score-row memory and then updates it, so the
// input takes no new word until the update of the last one is done.
// After the bottom-right node the block traces the path back through the
// direction memory, one memory read per move, rows+cols-2 moves in all. It
// then sends the moves in forward order, one word per cycle while out_stall_i
// is low, followed by one word with last_o set and the path score. Input is
// stalled from the last node until the score word is loaded.
// The output register holds its word while out_stall_i is high.
// Reset clears the counters and the output valid and sets both dimension
// registers to 16. Any register write on the APB port restarts the grid.
module grid_max_path_dp
  import gmpdp_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [WEIGHT_W-1:0]   weight_from_north_i,
  input  logic [WEIGHT_W-1:0]   weight_from_west_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  move_o,
  output logic [SCORE_W-1:0]    best_score_o,
  output logic                  last_o
);

  localparam int RowW       = $clog2(MAX_ROWS);
  localparam int ColW       = $clog2(MAX_COLS);
  localparam int CfnDepth   = MAX_ROWS * MAX_COLS;
  localparam int CfnAw      = $clog2(CfnDepth);
  localparam int MoveDepth  = MAX_ROWS + MAX_COLS - 2;
  localparam int CntW       = $clog2(MoveDepth + 1);

  gmpdp_state_e state_q, state_d;

  logic [CFG_W-1:0]     rows_in_use_q, cols_in_use_q;
  logic [RowW-1:0]      row_q, row_max, eff_row;
  logic [ColW-1:0]      col_q, col_max, eff_col;
  logic [SCORE_W-1:0]   west_q;
  logic [SCORE_W-1:0]   rd_score_q;
  logic [WEIGHT_W-1:0]  wn_q, ww_q;
  logic [RowW-1:0]      tb_row_q, tb_row_d;
  logic [ColW-1:0]      tb_col_q, tb_col_d;
  logic                 cfn_rd_q;
  logic [MoveDepth-1:0] stack_q;
  logic [CntW-1:0]      mv_cnt_q;
  logic [SCORE_W-1:0]   best_q;
  logic                 out_valid_q, move_q, last_q;
  logic [SCORE_W-1:0]   out_score_q;

  logic [SCORE_W-1:0]   score_mem [MAX_COLS];
  logic                 cfn_mem [CfnDepth];

  logic                 cfg_wr, accept, out_free, out_of_range;
  logic                 node_last_col, node_last_row, grid_done;
  logic [SCORE_W-1:0]   sum_n, sum_w, node_score;
  logic                 node_south, tb_move, tb_done;
  logic [CfnAw-1:0]     cfn_waddr, cfn_raddr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_COLS) ? APB_DATA_W'(cols_in_use_q)
                                         : APB_DATA_W'(rows_in_use_q);

  assign row_max = (rows_in_use_q == '0) ? '0 :
                   (int'(rows_in_use_q) >= MAX_ROWS) ? RowW'(MAX_ROWS - 1) :
                   RowW'(rows_in_use_q - 1'b1);
  assign col_max = (cols_in_use_q == '0) ? '0 :
                   (int'(cols_in_use_q) >= MAX_COLS) ? ColW'(MAX_COLS - 1) :
                   ColW'(cols_in_use_q - 1'b1);

  assign out_of_range = (row_q > row_max) || (col_q > col_max);
  assign eff_row      = out_of_range ? '0 : row_q;
  assign eff_col      = out_of_range ? '0 : col_q;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Add-compare-select for the node held in row_q and col_q.
  assign sum_n = sat_add(rd_score_q, wn_q);
  assign sum_w = sat_add(west_q, ww_q);

  always_comb begin
    if (row_q == '0 && col_q == '0) begin
      node_score = '0;
      node_south = 1'b0;
    end else if (row_q == '0) begin
      node_score = sum_w;
      node_south = 1'b0;
    end else if (col_q == '0) begin
      node_score = sum_n;
      node_south = 1'b1;
    end else if (sum_n >= sum_w) begin
      node_score = sum_n;
      node_south = 1'b1;
    end else begin
      node_score = sum_w;
      node_south = 1'b0;
    end
  end

  assign node_last_col = (col_q == col_max);
  assign node_last_row = (row_q == row_max);
  assign grid_done     = node_last_col && node_last_row;

  assign cfn_waddr = CfnAw'(int'(row_q) * MAX_COLS + int'(col_q));
  assign cfn_raddr = CfnAw'(int'(tb_row_q) * MAX_COLS + int'(tb_col_q));

  // Traceback step.
  assign tb_move  = (tb_row_q == '0) ? 1'b0 : (tb_col_q == '0) ? 1'b1 : cfn_rd_q;
  assign tb_row_d = tb_move ? RowW'(tb_row_q - 1'b1) : tb_row_q;
  assign tb_col_d = tb_move ? tb_col_q : ColW'(tb_col_q - 1'b1);
  assign tb_done  = (tb_row_d == '0) && (tb_col_d == '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (!grid_done) state_d = ST_IDLE;
        else if (row_q == '0 && col_q == '0) state_d = ST_SCORE;
        else state_d = ST_TB_RD;
      end
      ST_TB_RD: begin
        state_d = ST_TB_MV;
      end
      ST_TB_MV: begin
        if (tb_done) state_d = ST_EMIT;
        else state_d = ST_TB_RD;
      end
      ST_EMIT: begin
        if (out_free && mv_cnt_q == CntW'(1)) state_d = ST_SCORE;
      end
      ST_SCORE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rows_in_use_q <= DIM_RESET;
      cols_in_use_q <= DIM_RESET;
      row_q         <= '0;
      col_q         <= '0;
      west_q        <= '0;
      mv_cnt_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (paddr[2] == REG_COLS) cols_in_use_q <= pwdata[CFG_W-1:0];
        else rows_in_use_q <= pwdata[CFG_W-1:0];
        row_q  <= '0;
        col_q  <= '0;
        west_q <= '0;
      end else if (accept) begin
        row_q <= eff_row;
        col_q <= eff_col;
        if (out_of_range) west_q <= '0;
      end else if (state_q == ST_CALC) begin
        if (!node_last_col) begin
          col_q  <= ColW'(col_q + 1'b1);
          west_q <= node_score;
        end else begin
          col_q  <= '0;
          west_q <= '0;
          row_q  <= node_last_row ? '0 : RowW'(row_q + 1'b1);
        end
      end
      if (state_q == ST_CALC) mv_cnt_q <= '0;
      else if (state_q == ST_TB_MV) mv_cnt_q <= CntW'(mv_cnt_q + 1'b1);
      else if (state_q == ST_EMIT && out_free) mv_cnt_q <= CntW'(mv_cnt_q - 1'b1);
      if ((state_q == ST_EMIT || state_q == ST_SCORE) && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wn_q <= weight_from_north_i;
      ww_q <= weight_from_west_i;
    end
    if (state_q == ST_CALC && grid_done) begin
      best_q   <= node_score;
      tb_row_q <= row_q;
      tb_col_q <= col_q;
    end
    if (state_q == ST_TB_MV) begin
      tb_row_q <= tb_row_d;
      tb_col_q <= tb_col_d;
      stack_q  <= {stack_q[MoveDepth-2:0], tb_move};
    end
    if (state_q == ST_EMIT && out_free) begin
      move_q      <= stack_q[0];
      out_score_q <= '0;
      last_q      <= 1'b0;
      stack_q     <= stack_q >> 1;
    end
    if (state_q == ST_SCORE && out_free) begin
      move_q      <= 1'b0;
      out_score_q <= best_q;
      last_q      <= 1'b1;
    end
  end

  // Score-row memory.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) score_mem[col_q] <= node_score;
    if (accept) rd_score_q <= score_mem[eff_col];
  end

  // Direction memory.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) cfn_mem[cfn_waddr] <= node_south;
    if (state_q == ST_TB_RD) cfn_rd_q <= cfn_mem[cfn_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign move_o       = move_q;
  assign best_score_o = out_score_q;
  assign last_o       = last_q;

`ifndef ASSERT_OFF
  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_CALC))
    else $error("accepted word did not start a node update");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(mv_cnt_q) <= MoveDepth))
    else $error("move stack overflow");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (mv_cnt_q != '0))
    else $error("emitting from an empty move stack");

  a_tb_not_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TB_MV) |-> (tb_row_q != '0 || tb_col_q != '0))
    else $error("traceback stepped past the start node");
`endif

endmodule
